// ===== rtl/lmse_pkg.sv =====
package lmse_pkg;

   localparam int unsigned GLYPH_COUNT_DEF = 21;
   localparam int unsigned ROM_GLYPHS      = 21;
   localparam int unsigned ROM_BYTES       = ROM_GLYPHS * 8;
   localparam logic [7:0]  CODE_BASE       = 8'h41;
   localparam int unsigned FRAME_ROWS      = 8;

   localparam logic [2:0] KIND_REFRESH     = 3'd0;
   localparam logic [2:0] KIND_LOAD        = 3'd1;
   localparam logic [2:0] KIND_SHIFT_LEFT  = 3'd2;
   localparam logic [2:0] KIND_SHIFT_UP    = 3'd3;
   localparam logic [2:0] KIND_ROTATE_UP   = 3'd4;
   localparam logic [2:0] KIND_ROTATE_LEFT = 3'd5;
   localparam logic [2:0] KIND_CLEAR       = 3'd6;

   typedef logic [FRAME_ROWS-1:0][7:0] frame_type;

   typedef struct packed {
      logic       accept;
      logic [2:0] kind;
      logic [7:0] glyph_code;
      logic [2:0] step_index;
   } cmd_type;

   localparam logic [7:0] GLYPH_ROM [ROM_BYTES] = '{
      8'h00, 8'hF8, 8'h24, 8'h22, 8'h22, 8'h24, 8'hF8, 8'h00,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
      8'h00, 8'h38, 8'h44, 8'h82, 8'h82, 8'h82, 8'h44, 8'h00,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
      8'h00, 8'hFE, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
      8'h00, 8'h7E, 8'h80, 8'h80, 8'h80, 8'h80, 8'h7E, 8'h00
   };

   // blank glyph for codes below the font or beyond the loaded glyphs
   function automatic logic [7:0] glyph_byte(input logic [7:0] code,
                                             input logic [2:0] row,
                                             input int unsigned count);
      logic [7:0] idx;
      logic [7:0] addr;
      logic [7:0] result;
      idx    = code - CODE_BASE;
      addr   = {idx[4:0], row};
      result = 8'h00;
      if (code >= CODE_BASE && int'(idx) < int'(count) && int'(idx) < int'(ROM_GLYPHS)) begin
         result = GLYPH_ROM[addr];
      end
      return result;
   endfunction

endpackage

// ===== rtl/lmse_frame.sv =====
module lmse_frame #(
   parameter int unsigned GLYPH_COUNT = lmse_pkg::GLYPH_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  lmse_pkg::cmd_type   cmd,
   output lmse_pkg::frame_type frame
);

   lmse_pkg::frame_type frame_ff;
   lmse_pkg::frame_type frame_in;
   lmse_pkg::frame_type glyph;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         glyph[i] = lmse_pkg::glyph_byte(cmd.glyph_code, 3'(i), GLYPH_COUNT);
      end
   end

   always_comb begin
      frame_in = frame_ff;
      if (cmd.accept) begin
         unique case (cmd.kind)
            lmse_pkg::KIND_LOAD: begin
               frame_in = glyph;
            end
            lmse_pkg::KIND_SHIFT_LEFT: begin
               for (int i = 0; i < 7; i++) begin
                  frame_in[i] = frame_ff[i+1];
               end
               frame_in[7] = glyph[cmd.step_index];
            end
            lmse_pkg::KIND_SHIFT_UP: begin
               for (int i = 0; i < 8; i++) begin
                  frame_in[i] = {glyph[i][cmd.step_index], frame_ff[i][7:1]};
               end
            end
            lmse_pkg::KIND_ROTATE_UP: begin
               for (int i = 0; i < 8; i++) begin
                  frame_in[i] = {frame_ff[i][0], frame_ff[i][7:1]};
               end
            end
            lmse_pkg::KIND_ROTATE_LEFT: begin
               for (int i = 0; i < 7; i++) begin
                  frame_in[i] = frame_ff[i+1];
               end
               frame_in[7] = frame_ff[0];
            end
            lmse_pkg::KIND_CLEAR: begin
               frame_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
      end else begin
         frame_ff <= frame_in;
      end
   end

   assign frame = frame_ff;

endmodule

// ===== rtl/lmse_serializer.sv =====
module lmse_serializer (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  lmse_pkg::frame_type frame,
   output logic                free,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [3:0]          out_addr,
   output logic [7:0]          out_value,
   output logic                out_last
);

   lmse_pkg::frame_type snap_ff;
   lmse_pkg::frame_type snap_in;
   logic [2:0]          cnt_ff;
   logic [2:0]          cnt_in;
   logic                busy_ff;
   logic                busy_in;
   logic                take;

   assign take = busy_ff && out_ready;
   assign free = !busy_ff || (out_ready && cnt_ff == 3'd7);

   always_comb begin
      snap_in = snap_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (take) begin
         // advance to the next row
         snap_in = {8'h00, snap_ff[7:1]};
         cnt_in  = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end
      if (start) begin
         snap_in = frame;
         cnt_in  = 3'd0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 3'd0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
      snap_ff <= snap_in;
   end

   assign out_valid = busy_ff;
   assign out_addr  = {1'b0, cnt_ff} + 4'd1;
   assign out_value = snap_ff[0];
   assign out_last  = (cnt_ff == 3'd7);

endmodule

// ===== rtl/led_matrix_scroll_engine.sv =====
// channel | dir | tdata (low bit up)               | tuser    | tlast
// req_    | in  | glyph_code[7:0], step_index[10:8] | kind[2:0] | -
// rsp_    | out | row_addr[3:0], row_value[11:4]    | -         | last
//
// Frame commands are accepted back to back.
// A refresh snapshots the frame and drives eight rows, one per cycle while rsp_tready is high,
// from the output row register; frame commands keep flowing meanwhile.
// A new refresh waits until the eighth row of the previous one is taken.
// Reset is synchronous and clears the frame to all zeros.
module led_matrix_scroll_engine #(
   parameter int unsigned GLYPH_COUNT = lmse_pkg::GLYPH_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // glyph_code[7:0], step_index[10:8], zero[15:11]
   input  logic [2:0]  req_tuser,   // kind[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // row_addr[3:0], row_value[11:4], zero[15:12]
   output logic        rsp_tlast
);

   lmse_pkg::cmd_type   cmd;
   lmse_pkg::frame_type frame;
   logic                free;
   logic                is_refresh;
   logic                start;
   logic [3:0]          out_addr;
   logic [7:0]          out_value;

   assign is_refresh = (req_tuser == lmse_pkg::KIND_REFRESH);
   assign req_tready = free || !is_refresh;
   assign start      = req_tvalid && req_tready && is_refresh;

   assign cmd.accept     = req_tvalid && req_tready;
   assign cmd.kind       = req_tuser;
   assign cmd.glyph_code = req_tdata[7:0];
   assign cmd.step_index = req_tdata[10:8];

   lmse_frame #(
      .GLYPH_COUNT(GLYPH_COUNT)
   ) u_frame (
      .clock(clock),
      .reset(reset),
      .cmd  (cmd),
      .frame(frame)
   );

   lmse_serializer u_serializer (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .frame    (frame),
      .free     (free),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_addr (out_addr),
      .out_value(out_value),
      .out_last (rsp_tlast)
   );

   assign rsp_tdata = {4'h0, out_value, out_addr};

`ifndef ASSERT_OFF
   a_refresh_starts: assert property (@(posedge clock) disable iff (reset)
      start |=> rsp_tvalid && rsp_tdata[3:0] == 4'd1)
      else $error("refresh did not start at row one");

   a_row_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tdata[3:0] == $past(rsp_tdata[3:0]) + 4'd1)
      else $error("refresh row sequence broken");

   a_clear_frame: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && cmd.kind == lmse_pkg::KIND_CLEAR |=> frame == '0)
      else $error("clear left frame bits set");

   a_refresh_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !(rsp_tready && rsp_tlast) && is_refresh |-> !req_tready)
      else $error("refresh accepted while rows pending");
`endif

endmodule
